// ===== rtl/integer_to_padded_decimal_text_assert.svh =====
// ----------------------------------------------------------------------------
// integer_to_padded_decimal_text assertion macros
// concurrent assertion helpers, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_PADDED_DECIMAL_TEXT_ASSERT_SVH
`define INTEGER_TO_PADDED_DECIMAL_TEXT_ASSERT_SVH

`ifndef SYNTH
`define ITPDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itpdt assertion failed");
`define ITPDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itpdt assertion failed");
`else
`define ITPDT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ITPDT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/itpdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpdt_pkg
// shared constants, types and helpers of the decimal text converter
// ----------------------------------------------------------------------------
package itpdt_pkg;

  localparam int DefValueBits     = 32;
  localparam int DefMaxFieldWidth = 64;
  localparam int FieldWidthBits   = 7;
  localparam int CharBits         = 8;

  localparam logic [CharBits-1:0] ChrZero  = 8'h30;
  localparam logic [CharBits-1:0] ChrMinus = 8'h2D;
  localparam logic [CharBits-1:0] ChrSpace = 8'h20;

  // decimal digits of 2^(bits-1), the largest magnitude
  function automatic int dec_digits(input int bits);
    return ((bits - 1) * 30103) / 100000 + 1;
  endfunction

  typedef enum logic [2:0] {
    StIdle,
    StConvert,
    StTrim,
    StSetup,
    StPad,
    StSign,
    StDigits
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic trim;
    logic setup;
    logic emit_space;
    logic emit_minus;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic bits_last;
    logic trim_ok;
    logic pad_zero;
    logic neg;
    logic last_digit;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/itpdt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpdt_ctrl
// sequencer: binary to bcd, leading zero trim, then character emission
// ----------------------------------------------------------------------------
module itpdt_ctrl
  import itpdt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConvert;
        end
      end
      StConvert: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.bits_last) begin
          state_d = StTrim;
        end
      end
      StTrim: begin
        if (sts_i.trim_ok) begin
          cmd_o.trim = 1'b1;
        end else begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StPad;
      end
      StPad: begin
        if (sts_i.pad_zero) begin
          state_d = sts_i.neg ? StSign : StDigits;
        end else if (sts_i.out_free) begin
          cmd_o.emit_space = 1'b1;
        end
      end
      StSign: begin
        if (sts_i.out_free) begin
          cmd_o.emit_minus = 1'b1;
          state_d          = StDigits;
        end
      end
      StDigits: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.last_digit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/itpdt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpdt_dp
// magnitude, shift-add-3 bcd register, pad counter and output register
// ----------------------------------------------------------------------------
module itpdt_dp
  import itpdt_pkg::*;
#(
  parameter int VALUE_BITS      = DefValueBits,
  parameter int MAX_FIELD_WIDTH = DefMaxFieldWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [VALUE_BITS-1:0]     value_i,
  input  logic [FieldWidthBits-1:0] field_width_i,
  input  dp_cmd_t                   cmd_i,
  output dp_sts_t                   sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CharBits-1:0]       character_o,
  output logic                      last_o
);

  localparam int Digits   = dec_digits(VALUE_BITS);
  localparam int BcdBits  = Digits * 4;
  localparam int NdigBits = $clog2(Digits + 1);
  localparam int CntBits  = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]     bin_q, bin_d;
  logic [BcdBits-1:0]        bcd_q, bcd_d, bcd_adj;
  logic [CntBits-1:0]        bitcnt_q, bitcnt_d;
  logic [NdigBits-1:0]       ndig_q, ndig_d;
  logic                      neg_q, neg_d;
  logic [FieldWidthBits-1:0] width_q, width_d;
  logic [FieldWidthBits-1:0] pad_q, pad_d;
  logic [FieldWidthBits-1:0] text_len;
  logic [CharBits-1:0]       char_q, char_d;
  logic                      last_q, last_d;
  logic                      out_valid_q, out_valid_d;
  logic [3:0]                top_digit;
  logic                      in_neg;
  logic [VALUE_BITS-1:0]     in_mag;

  assign in_neg    = value_i[VALUE_BITS-1];
  assign in_mag    = in_neg ? (~value_i + 1'b1) : value_i;
  assign top_digit = bcd_q[BcdBits-1 -: 4];
  assign text_len  = FieldWidthBits'(ndig_q) + FieldWidthBits'(neg_q);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    bitcnt_d    = bitcnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    width_d     = width_q;
    pad_d       = pad_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (cmd_i.load) begin
      bin_d    = in_mag;
      bcd_d    = '0;
      bitcnt_d = CntBits'(VALUE_BITS);
      ndig_d   = NdigBits'(Digits);
      neg_d    = in_neg;
      width_d  = (field_width_i > FieldWidthBits'(MAX_FIELD_WIDTH))
               ? FieldWidthBits'(MAX_FIELD_WIDTH) : field_width_i;
    end
    if (cmd_i.dabble) begin
      bcd_d    = {bcd_adj[BcdBits-2:0], bin_q[VALUE_BITS-1]};
      bin_d    = {bin_q[VALUE_BITS-2:0], 1'b0};
      bitcnt_d = bitcnt_q - 1'b1;
    end
    if (cmd_i.trim) begin
      bcd_d  = {bcd_q[BcdBits-5:0], 4'd0};
      ndig_d = ndig_q - 1'b1;
    end
    if (cmd_i.setup) begin
      pad_d = (width_q > text_len) ? width_q - text_len : '0;
    end
    if (cmd_i.emit_space) begin
      pad_d       = pad_q - 1'b1;
      char_d      = ChrSpace;
      last_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_minus) begin
      char_d      = ChrMinus;
      last_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_digit) begin
      bcd_d       = {bcd_q[BcdBits-5:0], 4'd0};
      ndig_d      = ndig_q - 1'b1;
      char_d      = ChrZero + CharBits'(top_digit);
      last_d      = (ndig_q == NdigBits'(1));
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q    <= bin_d;
    bcd_q    <= bcd_d;
    bitcnt_q <= bitcnt_d;
    ndig_q   <= ndig_d;
    neg_q    <= neg_d;
    width_q  <= width_d;
    pad_q    <= pad_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  always_comb begin
    sts_o.bits_last  = (bitcnt_q == CntBits'(1));
    sts_o.trim_ok    = (top_digit == 4'd0) && (ndig_q > NdigBits'(1));
    sts_o.pad_zero   = (pad_q == '0);
    sts_o.neg        = neg_q;
    sts_o.last_digit = (ndig_q == NdigBits'(1));
    sts_o.out_free   = ~out_valid_q | out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/integer_to_padded_decimal_text.sv =====
`timescale 1ns / 1ps
// bcd conversion by shift-add-3, leading zero trim and pad setup precede the first character
// a new integer is accepted only after the last digit of the previous one has been emitted
// characters leave one per cycle unless m_axis_tready_i stalls them,
// but none leaves on the step from the padding to the sign or digits
// reset: rst_ni asynchronous active low, clears the sequencer and output valid
// ----------------------------------------------------------------------------
// integer_to_padded_decimal_text
// signed integer to right-justified decimal ascii character stream
// ----------------------------------------------------------------------------
`include "integer_to_padded_decimal_text_assert.svh"

module integer_to_padded_decimal_text
  import itpdt_pkg::*;
#(
  parameter int VALUE_BITS      = DefValueBits,
  parameter int MAX_FIELD_WIDTH = DefMaxFieldWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // value, then field_width, zero filled to whole bytes
  input  logic [((VALUE_BITS + FieldWidthBits + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // character
  output logic [CharBits-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  itpdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itpdt_dp #(
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (s_axis_tdata_i[VALUE_BITS-1:0]),
    .field_width_i (s_axis_tdata_i[VALUE_BITS +: FieldWidthBits]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .character_o   (m_axis_tdata_o),
    .last_o        (m_axis_tlast_o)
  );

  `ITPDT_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd))
  `ITPDT_ASSERT_IMP(a_emit_free, clk_i, rst_ni, cmd.emit_space || cmd.emit_minus || cmd.emit_digit, sts.out_free)
  `ITPDT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `ITPDT_ASSERT_NXT(a_idle_after_last, clk_i, rst_ni, cmd.emit_digit && sts.last_digit, s_axis_tready_o && m_axis_tlast_o)

endmodule

// ===== tb/integer_to_padded_decimal_text_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_padded_decimal_text_tb
// drives signed integers with field widths into the converter and checks every
// character and last flag against typed row text or an in-bench model of the padded text
// ----------------------------------------------------------------------------
module integer_to_padded_decimal_text_tb;
  import itpdt_pkg::*;

  localparam int DataBits    = ((DefValueBits + FieldWidthBits + 7) / 8) * 8;
  localparam int NumBase     = 10;
  localparam int ResetCycles = 7;
  localparam int TailCycles  = 100;
  localparam int RandomItems = 450;
  localparam int NumRows     = 24;
  localparam int StallPeriod = 150;

  typedef struct packed {
    logic [CharBits-1:0] chr;
    logic                last;
  } text_char_t;

  typedef struct {
    logic [DefValueBits-1:0]   value;
    logic [FieldWidthBits-1:0] width;
    string                     text;
  } text_row_t;

  typedef enum int {
    KindAny,
    KindSmall,
    KindDecade,
    KindExtreme,
    KindDigits
  } value_kind_e;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                s_valid = 1'b0;
  logic [DataBits-1:0] s_data  = '0;
  logic                m_ready = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic [CharBits-1:0] m_data;
  logic                m_last;

  text_char_t pending_chars[$];
  text_char_t want;
  int         err_count   = 0;
  int         items_sent  = 0;
  int         chars_seen  = 0;
  int         text_len    = 0;
  int         longest     = 0;
  int         neg_count   = 0;
  int         clamp_count = 0;
  int         burst_left  = 0;
  int         stall_tick  = 0;
  int         stall_mode  = 0;

  integer_to_padded_decimal_text u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // value, field_width, zero fill
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // character
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("integer_to_padded_decimal_text_tb: errors");
    $finish;
  end

  // expected characters of one conversion, appended to the pending store
  function automatic void predict_text(input logic [DefValueBits-1:0] value,
                                       input logic [FieldWidthBits-1:0] field_width);
    logic [DefValueBits-1:0] mag;
    logic [CharBits-1:0]     rev [0:15];
    logic                    neg;
    int                      n;
    int                      w;
    int                      total;
    neg = value[DefValueBits-1];
    // two's complement negate also maps the most negative value onto its magnitude
    mag = neg ? -value : value;
    n = 0;
    do begin
      rev[n] = ChrZero + CharBits'(mag % NumBase);
      mag = mag / NumBase;
      n++;
    end while (mag != 0);
    if (neg) begin
      rev[n] = ChrMinus;
      n++;
    end
    w = (field_width > DefMaxFieldWidth) ? DefMaxFieldWidth : int'(field_width);
    total = (w > n) ? w : n;
    repeat (total - n) pending_chars.push_back('{ChrSpace, 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      pending_chars.push_back('{rev[k], k == 0});
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    err_count++;
  endtask

  // one transaction on the input side, with burst pacing ahead of it
  task automatic send_item(input logic [DefValueBits-1:0] value,
                           input logic [FieldWidthBits-1:0] field_width,
                           input string typed_text);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
      gap = $urandom_range(1, 8);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= DataBits'({field_width, value});
    do @(posedge clk_i); while (!s_ready);
    if (typed_text.len() != 0) begin
      for (int i = 0; i < typed_text.len(); i++) begin
        pending_chars.push_back('{CharBits'(typed_text[i]), i == typed_text.len() - 1});
      end
    end else begin
      predict_text(value, field_width);
    end
    items_sent++;
    if (value[DefValueBits-1]) neg_count++;
    if (field_width > DefMaxFieldWidth) clamp_count++;
  endtask

  // hold the input side until every pending character has arrived
  task automatic drain_pending();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      chars_seen++;
      text_len++;
      if (pending_chars.size() == 0) begin
        report_mismatch("character with nothing pending", 0, m_data);
      end else begin
        want = pending_chars.pop_front();
        if (m_data !== want.chr) report_mismatch("character", want.chr, m_data);
        if (m_last !== want.last) report_mismatch("last flag", want.last, m_last);
      end
      if (m_last) begin
        if (text_len > longest) longest = text_len;
        text_len = 0;
      end
    end
    stall_tick++;
    if (stall_tick % StallPeriod == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 3) != 0);
      2: m_ready <= (stall_tick % 3 == 0);
      default: m_ready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  initial begin
    text_row_t               rows [NumRows];
    value_kind_e             kind;
    logic [DefValueBits-1:0] v;
    logic [FieldWidthBits-1:0] fw;
    longint unsigned         decade;
    int                      r;

    // empty text means the row is checked against the predictor
    rows = '{
      '{32'd0,          7'd0,   "0"},
      '{32'd0,          7'd1,   "0"},
      '{32'd0,          7'd3,   "  0"},
      '{32'h8000_0000,  7'd0,   "-2147483648"},
      '{32'h8000_0000,  7'd11,  "-2147483648"},
      '{32'h8000_0000,  7'd12,  " -2147483648"},
      '{32'h7fff_ffff,  7'd0,   "2147483647"},
      '{32'h7fff_ffff,  7'd127, ""},
      '{-32'sd1,        7'd0,   "-1"},
      '{-32'sd1,        7'd2,   "-1"},
      '{-32'sd1,        7'd4,   "  -1"},
      '{32'd1,          7'd0,   "1"},
      '{32'd9,          7'd1,   "9"},
      '{32'd10,         7'd1,   "10"},
      '{-32'sd10,       7'd5,   "  -10"},
      '{32'd99999,      7'd6,   " 99999"},
      '{32'd1000000000, 7'd0,   "1000000000"},
      '{-32'sd999999999, 7'd20, ""},
      '{32'd7,          7'd63,  ""},
      '{32'd7,          7'd64,  ""},
      '{32'd7,          7'd65,  ""},
      '{32'd12345,      7'd100, ""},
      '{32'h5555_5555,  7'd7,   "1431655765"},
      '{32'haaaa_aaaa,  7'd0,   "-1431655766"}
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].value, rows[i].width, rows[i].text);
    drain_pending();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) drain_pending();
      kind = value_kind_e'($urandom_range(0, 4));
      case (kind)
        KindAny:   v = $urandom;
        KindSmall: v = DefValueBits'($urandom_range(0, 198)) - 32'd99;
        KindDecade: begin
          decade = 1;
          repeat ($urandom_range(0, 9)) decade = decade * NumBase;
          // just below, at and just above a power of ten
          v = DefValueBits'(decade + $urandom_range(0, 2) - 1);
          if ($urandom_range(0, 1) != 0) v = -v;
        end
        KindExtreme: begin
          case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'd0;
            3: v = '1;
            default: v = 32'd1;
          endcase
        end
        default: begin
          decade = 1;
          repeat ($urandom_range(1, 9)) decade = decade * NumBase;
          v = DefValueBits'($urandom % decade);
          if ($urandom_range(0, 1) != 0) v = -v;
        end
      endcase
      r = $urandom_range(0, 19);
      if (r < 16) fw = FieldWidthBits'($urandom_range(0, 12));
      else if (r < 19) fw = FieldWidthBits'($urandom_range(13, 64));
      else fw = FieldWidthBits'($urandom_range(65, 127));
      send_item(v, fw, "");
    end

    drain_pending();
    repeat (TailCycles) @(posedge clk_i);

    $display("converted %0d integers into %0d characters, longest text %0d",
             items_sent, chars_seen, longest);
    $display("%0d negative values, %0d widths above the clamp", neg_count, clamp_count);
    if (err_count == 0) begin
      $display("integer_to_padded_decimal_text_tb: clean");
    end else begin
      $display("integer_to_padded_decimal_text_tb: errors");
    end
    $finish;
  end

endmodule
